// ===== rtl/lidar_point_camera_projection_defines.svh =====
// Assertion macros shared by the projection block.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_DEFINES_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LPCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LPCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpcp_pkg.sv =====
// Shared types, constants and helpers of the lidar projection block.
`timescale 1ns / 1ps
`default_nettype none
package lpcp_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ProdW    = CoefW + CoordW;
  localparam int unsigned CamW     = 42;
  localparam int unsigned NumW     = 58;
  localparam int unsigned QuotW    = 18;
  localparam int unsigned RemW     = CamW + 1;
  localparam int unsigned XformLat = 3;
  localparam int unsigned DivLat   = QuotW + 1;
  localparam int unsigned PipeLat  = XformLat + DivLat;
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned DimW     = 13;

  localparam logic [11:0] MaxIntensity = 12'd2300;
  localparam logic [20:0] RecipIntens  = 21'd1867378;  // ceil(2^32 / 2300)
  localparam int unsigned RecipShift   = 32;

  typedef enum logic [2:0] {
    CFG_ROW_X     = 3'd0,
    CFG_ROW_Y     = 3'd1,
    CFG_ROW_Z     = 3'd2,
    CFG_FOCAL     = 3'd3,
    CFG_PRINCIPAL = 3'd4,
    CFG_IMAGE     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    logic signed [NumW-1:0] num_u;
    logic signed [NumW-1:0] num_v;
    logic        [CamW-1:0] den;
    logic                   zpos;
  } xform_t;

  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             rem_nz;
    logic             neg;
    logic             ovf;
  } div_res_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    color_t color;
    logic   zpos;
  } side_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [15:0] d);
    if (d > 16'(MaxDim)) begin
      clamp_dim = DimW'(MaxDim);
    end else begin
      clamp_dim = d[DimW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lidar_point_camera_projection.sv =====
// Top level of the lidar point to camera pixel projection pipeline.
//
// Each transaction on the input channel carries one lidar point and yields
// exactly one result transaction, in order. The pipeline takes a new point
// every cycle while the output is not stalled. A point passes 23 register
// stages. The stages are three for the transform products, row sums and
// focal products, nineteen for the divider (one range-check stage plus one
// stage per quotient bit of the 18-bit pixel quotient), and one for the final
// offset, bounds check and output register. The first of them loads at the
// accepting edge. The colour ramp runs alongside the transform in three
// stages. When the output is stalled the whole pipeline holds, so in_stall_o
// follows out_stall_i while a result waits. Configuration registers must be
// written only while the pipeline is empty; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_point_camera_projection_defines.svh"
module lidar_point_camera_projection (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [23:0] point_x_i,
  input  wire logic signed [23:0] point_y_i,
  input  wire logic signed [23:0] point_z_i,
  input  wire logic [15:0]        intensity_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               in_view_o,
  output      logic [11:0]        pixel_u_o,
  output      logic [11:0]        pixel_v_o,
  output      logic [7:0]         color_blue_o,
  output      logic [7:0]         color_green_o,
  output      logic [7:0]         color_red_o
);
  import lpcp_pkg::*;

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_X:     cfg_q.row_x <= cfg_data_i;
        CFG_ROW_Y:     cfg_q.row_y <= cfg_data_i;
        CFG_ROW_Z:     cfg_q.row_z <= cfg_data_i;
        CFG_FOCAL:     {cfg_q.fy, cfg_q.fx} <= cfg_data_i[31:0];
        CFG_PRINCIPAL: {cfg_q.cy, cfg_q.cx} <= cfg_data_i[31:0];
        CFG_IMAGE:     {cfg_q.height, cfg_q.width} <= cfg_data_i[31:0];
        default:       ;
      endcase
    end
  end

  // The pipeline advances as one unit unless a finished result is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic vld_q [PipeLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PipeLat; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < PipeLat; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  xform_t xf;
  color_t color;

  lpcp_transform u_transform (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .x_i   (point_x_i),
    .y_i   (point_y_i),
    .z_i   (point_z_i),
    .xf_o  (xf)
  );

  lpcp_color u_color (
    .clk_i       (clk_i),
    .en_i        (en),
    .intensity_i (intensity_i),
    .color_o     (color)
  );

  div_res_t res_u, res_v;

  lpcp_divider u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (xf.num_u),
    .den_i (xf.den),
    .res_o (res_u)
  );

  lpcp_divider u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (xf.num_v),
    .den_i (xf.den),
    .res_o (res_v)
  );

  // Sideband that travels next to the divider stages.
  side_t side_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{color: color, zpos: xf.zpos};
      for (int k = 1; k < DivLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Final stage: floor the quotient, add the principal point, bounds check.
  logic [DimW-1:0]   w_dim, h_dim;
  logic [DimW+3:0]   w_lim, h_lim;
  logic signed [QuotW+1:0] q_u, q_v;
  logic signed [QuotW+2:0] pos_u, pos_v;
  logic              ok_u, ok_v, view_d;

  assign w_dim = clamp_dim(cfg_q.width);
  assign h_dim = clamp_dim(cfg_q.height);
  assign w_lim = {w_dim, 4'd0};
  assign h_lim = {h_dim, 4'd0};

  always_comb begin
    // Floor division rounds a negative inexact quotient one step further down.
    q_u = res_u.neg ? (-$signed({2'b00, res_u.quot}) - $signed({19'd0, res_u.rem_nz}))
                    : $signed({2'b00, res_u.quot});
    q_v = res_v.neg ? (-$signed({2'b00, res_v.quot}) - $signed({19'd0, res_v.rem_nz}))
                    : $signed({2'b00, res_v.quot});
    pos_u  = {q_u[QuotW+1], q_u} + $signed({5'd0, cfg_q.cx});
    pos_v  = {q_v[QuotW+1], q_v} + $signed({5'd0, cfg_q.cy});
    ok_u   = !res_u.ovf && !pos_u[QuotW+2] && (pos_u[QuotW+1:0] < (QuotW+2)'(w_lim));
    ok_v   = !res_v.ovf && !pos_v[QuotW+2] && (pos_v[QuotW+1:0] < (QuotW+2)'(h_lim));
    view_d = side_q[DivLat-1].zpos && ok_u && ok_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[PipeLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_view_o     <= view_d;
      pixel_u_o     <= view_d ? pos_u[15:4] : 12'd0;
      pixel_v_o     <= view_d ? pos_v[15:4] : 12'd0;
      color_blue_o  <= view_d ? side_q[DivLat-1].color.blue  : 8'd0;
      color_green_o <= view_d ? side_q[DivLat-1].color.green : 8'd0;
      color_red_o   <= view_d ? side_q[DivLat-1].color.red   : 8'd0;
    end
  end

  // A result that is out of view carries no pixel and no colour.
  `LPCP_ASSERT_NOW(a_hidden_zero, out_valid_o && !in_view_o,
    pixel_u_o == 12'd0 && pixel_v_o == 12'd0 && color_blue_o == 8'd0 &&
    color_green_o == 8'd0 && color_red_o == 8'd0, "hidden point has nonzero payload")

  // A visible pixel lies inside the clamped image.
  `LPCP_ASSERT_NOW(a_in_bounds, out_valid_o && in_view_o,
    DimW'(pixel_u_o) < w_dim && DimW'(pixel_v_o) < h_dim, "pixel outside image")

  // A held result keeps its pixel while the receiver stalls.
  `LPCP_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(pixel_u_o) && $stable(pixel_v_o), "stalled result changed")

endmodule
`default_nettype wire

// ===== rtl/lpcp_transform.sv =====
// Rigid transform into camera space followed by the focal-length products.
`timescale 1ns / 1ps
`default_nettype none
module lpcp_transform (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire lpcp_pkg::cfg_t                cfg_i,
  input  wire logic signed [23:0]            x_i,
  input  wire logic signed [23:0]            y_i,
  input  wire logic signed [23:0]            z_i,
  output      lpcp_pkg::xform_t              xf_o
);
  import lpcp_pkg::*;

  logic [2:0][63:0] rows;
  assign rows = {cfg_i.row_z, cfg_i.row_y, cfg_i.row_x};

  logic signed [CoordW-1:0] coord [3];
  assign coord[0] = x_i;
  assign coord[1] = y_i;
  assign coord[2] = z_i;

  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [CoefW-1:0] tr_q   [3];
  logic signed [CamW-1:0]  cam_d  [3];
  logic signed [CamW-1:0]  cam_q  [3];

  // Stage one: nine coefficient by coordinate products.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(rows[r][16*c +: 16]) * coord[c];
      end
    end
  end

  // Stage two: row sums with the translation scaled to the coordinate grid.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cam_d[r] = CamW'(prod_q[r][0]) + CamW'(prod_q[r][1]) + CamW'(prod_q[r][2])
               + (CamW'(tr_q[r]) <<< 10);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
        tr_q[r]  <= $signed(rows[r][63:48]);
        cam_q[r] <= cam_d[r];
      end
    end
  end

  // Stage three: scale by the focal lengths and form the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xf_o.num_u <= $signed({1'b0, cfg_i.fx}) * cam_q[0];
      xf_o.num_v <= $signed({1'b0, cfg_i.fy}) * cam_q[1];
      xf_o.zpos  <= (cam_q[2] > 0);
      xf_o.den   <= (cam_q[2] > 0) ? cam_q[2] : CamW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpcp_color.sv =====
// Three-stage intensity colour ramp with reciprocal division by the full scale.
`timescale 1ns / 1ps
`default_nettype none
module lpcp_color (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [15:0]     intensity_i,
  output      lpcp_pkg::color_t color_o
);
  import lpcp_pkg::*;

  logic [11:0] b_x, g_x, r_x;
  logic [17:0] dbl;
  logic [17:0] dev;
  logic        b_sat_d;
  logic [19:0] num_d [3];
  logic [19:0] num_q [3];
  logic        b_sat_q, b_sat2_q;
  logic [40:0] quo_q [3];

  always_comb begin
    b_sat_d = (intensity_i >= 16'(MaxIntensity));
    b_x     = b_sat_d ? 12'd0 : intensity_i[11:0];
    r_x     = b_sat_d ? 12'd0 : (MaxIntensity - intensity_i[11:0]);
    dbl     = {1'b0, intensity_i, 1'b0};
    dev     = (dbl >= 18'(MaxIntensity)) ? (dbl - 18'(MaxIntensity))
                                         : (18'(MaxIntensity) - dbl);
    g_x     = (dev < 18'(MaxIntensity)) ? (MaxIntensity - dev[11:0]) : 12'd0;
    // Times 255 as a shift and subtract.
    num_d[0] = ({8'd0, b_x} << 8) - {8'd0, b_x};
    num_d[1] = ({8'd0, g_x} << 8) - {8'd0, g_x};
    num_d[2] = ({8'd0, r_x} << 8) - {8'd0, r_x};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= num_d[k];
        quo_q[k] <= num_q[k] * RecipIntens;
      end
      b_sat_q       <= b_sat_d;
      b_sat2_q      <= b_sat_q;
      color_o.blue  <= b_sat2_q ? 8'hFF : quo_q[0][RecipShift +: 8];
      color_o.green <= quo_q[1][RecipShift +: 8];
      color_o.red   <= quo_q[2][RecipShift +: 8];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lpcp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with range detection.
`timescale 1ns / 1ps
`default_nettype none
module lpcp_divider (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [lpcp_pkg::NumW-1:0] num_i,
  input  wire logic [lpcp_pkg::CamW-1:0]       den_i,
  output      lpcp_pkg::div_res_t              res_o
);
  import lpcp_pkg::*;

  logic [RemW-1:0]  rem_q [QuotW+1];
  logic [QuotW-1:0] shf_q [QuotW+1];
  logic [CamW-1:0]  den_q [QuotW+1];
  logic             neg_q [QuotW+1];
  logic             ovf_q [QuotW+1];

  logic [NumW-1:0] mag;
  assign mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);

  // Prep stage: the quotient only matters below 2^QuotW, larger ones are flagged.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(mag[NumW-1:QuotW]);
      shf_q[0] <= mag[QuotW-1:0];
      den_q[0] <= den_i;
      neg_q[0] <= num_i[NumW-1];
      ovf_q[0] <= (CamW'(mag[NumW-1:QuotW]) >= den_i);
    end
  end

  for (genvar s = 1; s <= QuotW; s++) begin : g_step
    logic [RemW-1:0] trial;
    logic            take;
    assign trial = {rem_q[s-1][RemW-2:0], shf_q[s-1][QuotW-1]};
    assign take  = (trial >= RemW'(den_q[s-1]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? (trial - RemW'(den_q[s-1])) : trial;
        shf_q[s] <= {shf_q[s-1][QuotW-2:0], take};
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign res_o.quot   = shf_q[QuotW];
  assign res_o.rem_nz = (rem_q[QuotW] != '0);
  assign res_o.neg    = neg_q[QuotW];
  assign res_o.ovf    = ovf_q[QuotW];

endmodule
`default_nettype wire
